>>> rtl/mvp_pkg.sv
// ----------------------------------------------------------------------------
// mvp_pkg
// Shared types and constants of the matrix-vector product unit.
// ----------------------------------------------------------------------------
package mvp_pkg;

   localparam int DATA_WIDTH     = 16;
   localparam int PROD_WIDTH     = 2 * DATA_WIDTH;
   localparam int ACC_WIDTH      = 48;
   localparam int SUM_WIDTH      = 32;
   localparam int ROW_IDX_WIDTH  = 6;
   localparam int VEC_IDX_WIDTH  = 6;
   localparam int CFG_IDX_WIDTH  = 2;
   localparam int CFG_DATA_WIDTH = 7;
   localparam int DIM_WIDTH      = 7;
   localparam int SHIFT_WIDTH    = 5;
   localparam int QUEUE_DEPTH    = 2;

   localparam logic [DIM_WIDTH-1:0]   NUM_ROWS_RESET   = 7'd64;
   localparam logic [DIM_WIDTH-1:0]   NUM_COLS_RESET   = 7'd64;
   localparam logic [SHIFT_WIDTH-1:0] FRAC_SHIFT_RESET = 5'd15;

   typedef enum logic [CFG_IDX_WIDTH-1:0] {
      CFG_NUM_ROWS   = 2'd0,
      CFG_NUM_COLS   = 2'd1,
      CFG_FRAC_SHIFT = 2'd2
   } cfg_index_type;

   typedef enum logic {
      CMD_LOAD_VEC = 1'b0,
      CMD_MATRIX   = 1'b1
   } cmd_type;

   typedef struct packed {
      logic [DIM_WIDTH-1:0]   num_rows;
      logic [DIM_WIDTH-1:0]   num_cols;
      logic [SHIFT_WIDTH-1:0] frac_shift;
   } cfg_type;

   // one matrix element with its vector operand, as handed to the MAC side
   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] value;
      logic signed [DATA_WIDTH-1:0] xval;
      logic                         end_row;
      logic                         last;
      logic [ROW_IDX_WIDTH-1:0]     row_index;
   } job_type;

endpackage

>>> rtl/mvp_if.sv
// ----------------------------------------------------------------------------
// mvp_if
// Valid/ready channels of the matrix-vector product unit.
// ----------------------------------------------------------------------------
interface mvp_req_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   cmd;
   logic [mvp_pkg::VEC_IDX_WIDTH-1:0]      vec_index;
   logic signed [mvp_pkg::DATA_WIDTH-1:0]  value;

   modport source (output valid, cmd, vec_index, value, input ready);
   modport sink   (input valid, cmd, vec_index, value, output ready);
endinterface

interface mvp_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic [mvp_pkg::ROW_IDX_WIDTH-1:0]      row_index;
   logic signed [mvp_pkg::SUM_WIDTH-1:0]   sum;
   logic                                   saturated;
   logic                                   last;

   modport source (output valid, row_index, sum, saturated, last, input ready);
   modport sink   (input valid, row_index, sum, saturated, last, output ready);
endinterface

interface mvp_csr_if;
   logic                                   valid;
   logic                                   ready;
   logic [mvp_pkg::CFG_IDX_WIDTH-1:0]      index;
   logic [mvp_pkg::CFG_DATA_WIDTH-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/mvp_front.sv
// ----------------------------------------------------------------------------
// mvp_front
// Accepts requests, writes vector loads into the store, tags matrix elements
// with their vector operand, end of row and last row.
// ----------------------------------------------------------------------------
module mvp_front #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  mvp_pkg::cfg_type    cfg,
   mvp_req_if.sink             req_ch,
   output logic                job_valid,
   output mvp_pkg::job_type    job_data,
   input  logic                job_ready
);

   localparam int COL_W  = $clog2(MAX_COLS + 1);
   localparam int ROW_W  = $clog2(MAX_ROWS + 1);
   localparam int ADDR_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

   logic signed [mvp_pkg::DATA_WIDTH-1:0] vec_store_ff [MAX_COLS];

   logic [COL_W-1:0] col_ff, col_in, col_plus, cols_eff;
   logic [ROW_W-1:0] row_ff, row_in, row_plus, rows_eff;
   logic             job_valid_ff, job_valid_in;

   logic signed [mvp_pkg::DATA_WIDTH-1:0] value_ff, xval_ff;
   logic                                  end_row_ff, last_ff;
   logic [mvp_pkg::ROW_IDX_WIDTH-1:0]     row_idx_ff;

   logic accept, is_matrix, end_row, last_row, wr_in_range;
   logic [ADDR_W-1:0] wr_addr;

   assign req_ch.ready = !job_valid_ff || job_ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign is_matrix    = (req_ch.cmd == mvp_pkg::CMD_MATRIX);
   assign wr_in_range  = int'(req_ch.vec_index) < MAX_COLS;
   assign wr_addr      = ADDR_W'(req_ch.vec_index);

   always_comb begin
      priority if (cfg.num_cols == '0) begin
         cols_eff = COL_W'(1);
      end else if (int'(cfg.num_cols) > MAX_COLS) begin
         cols_eff = COL_W'(MAX_COLS);
      end else begin
         cols_eff = COL_W'(cfg.num_cols);
      end
   end

   always_comb begin
      priority if (cfg.num_rows == '0) begin
         rows_eff = ROW_W'(1);
      end else if (int'(cfg.num_rows) > MAX_ROWS) begin
         rows_eff = ROW_W'(MAX_ROWS);
      end else begin
         rows_eff = ROW_W'(cfg.num_rows);
      end
   end

   assign col_plus = col_ff + COL_W'(1);
   assign row_plus = row_ff + ROW_W'(1);
   assign end_row  = (col_plus >= cols_eff);
   assign last_row = (row_plus >= rows_eff);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept && is_matrix) begin
         if (end_row) begin
            col_in = '0;
            row_in = last_row ? '0 : row_plus;
         end else begin
            col_in = col_plus;
         end
      end
   end

   always_comb begin
      if (accept && is_matrix) begin
         job_valid_in = 1'b1;
      end else if (job_ready) begin
         job_valid_in = 1'b0;
      end else begin
         job_valid_in = job_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         job_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         job_valid_ff <= job_valid_in;
      end
   end

   // vector store, registered read at the current column
   always_ff @(posedge clock) begin
      if (accept && !is_matrix && wr_in_range) begin
         vec_store_ff[wr_addr] <= req_ch.value;
      end
      if (accept && is_matrix) begin
         xval_ff    <= vec_store_ff[col_ff[ADDR_W-1:0]];
         value_ff   <= req_ch.value;
         end_row_ff <= end_row;
         last_ff    <= last_row;
         row_idx_ff <= mvp_pkg::ROW_IDX_WIDTH'(row_ff);
      end
   end

   assign job_valid          = job_valid_ff;
   assign job_data.value     = value_ff;
   assign job_data.xval      = xval_ff;
   assign job_data.end_row   = end_row_ff;
   assign job_data.last      = last_ff;
   assign job_data.row_index = row_idx_ff;

endmodule

>>> rtl/mvp_queue.sv
// ----------------------------------------------------------------------------
// mvp_queue
// Short first-in first-out queue between the front and the MAC side.
// ----------------------------------------------------------------------------
module mvp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  mvp_pkg::job_type  push_data,
   output logic              push_ready,
   output logic              pop_valid,
   output mvp_pkg::job_type  pop_data,
   input  logic              pop_ready
);

   localparam int PTR_W = (mvp_pkg::QUEUE_DEPTH > 1) ? $clog2(mvp_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(mvp_pkg::QUEUE_DEPTH + 1);

   mvp_pkg::job_type entry_ff [mvp_pkg::QUEUE_DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != CNT_W'(mvp_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (int'(wr_ptr_ff) == mvp_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (int'(rd_ptr_ff) == mvp_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/mvp_back.sv
// ----------------------------------------------------------------------------
// mvp_back
// MAC side: multiply, accumulate, shift at end of row, saturate to 32 bits.
// ----------------------------------------------------------------------------
module mvp_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [mvp_pkg::SHIFT_WIDTH-1:0]      frac_shift,
   input  logic                                 job_valid,
   input  mvp_pkg::job_type                     job_data,
   output logic                                 job_ready,
   mvp_rsp_if.source                            rsp_ch
);

   localparam int ACC_W = mvp_pkg::ACC_WIDTH;
   localparam int SUM_W = mvp_pkg::SUM_WIDTH;
   localparam int RIW   = mvp_pkg::ROW_IDX_WIDTH;

   logic adv;

   // multiply stage
   logic                                  p_valid_ff, p_end_ff, p_last_ff;
   logic [RIW-1:0]                        p_row_ff;
   logic signed [mvp_pkg::PROD_WIDTH-1:0] prod_ff, prod_in;

   // accumulate stage
   logic signed [ACC_W-1:0] acc_ff, acc_in, acc_sum;
   logic                    s_valid_ff, s_valid_in, s_last_ff;
   logic [RIW-1:0]          s_row_ff;
   logic signed [ACC_W-1:0] s_sum_ff;

   // shift stage
   logic                    t_valid_ff, t_last_ff;
   logic [RIW-1:0]          t_row_ff;
   logic signed [ACC_W-1:0] t_sh_ff;

   // output register
   logic                    rsp_valid_ff, sat_ff, o_last_ff, sat_in;
   logic [RIW-1:0]          o_row_ff;
   logic signed [SUM_W-1:0] o_sum_ff, sum_in;

   assign adv       = !rsp_valid_ff || rsp_ch.ready;
   assign job_ready = adv;

   assign prod_in = $signed(job_data.value) * $signed(job_data.xval);
   assign acc_sum = acc_ff + ACC_W'(prod_ff);

   always_comb begin
      acc_in     = acc_ff;
      s_valid_in = 1'b0;
      if (p_valid_ff) begin
         if (p_end_ff) begin
            acc_in     = '0;
            s_valid_in = 1'b1;
         end else begin
            acc_in = acc_sum;
         end
      end
   end

   // clip when the bits above the 32-bit sign are not all copies of it
   always_comb begin
      sat_in = !((&t_sh_ff[ACC_W-1:SUM_W-1]) || !(|t_sh_ff[ACC_W-1:SUM_W-1]));
      if (sat_in) begin
         sum_in = t_sh_ff[ACC_W-1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         sum_in = t_sh_ff[SUM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff   <= 1'b0;
         s_valid_ff   <= 1'b0;
         t_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
      end else if (adv) begin
         p_valid_ff   <= job_valid;
         s_valid_ff   <= s_valid_in;
         t_valid_ff   <= s_valid_ff;
         rsp_valid_ff <= t_valid_ff;
         acc_ff       <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff   <= prod_in;
         p_end_ff  <= job_data.end_row;
         p_last_ff <= job_data.last;
         p_row_ff  <= job_data.row_index;
         s_sum_ff  <= acc_sum;
         s_last_ff <= p_last_ff;
         s_row_ff  <= p_row_ff;
         t_sh_ff   <= s_sum_ff >>> frac_shift;
         t_last_ff <= s_last_ff;
         t_row_ff  <= s_row_ff;
         o_sum_ff  <= sum_in;
         sat_ff    <= sat_in;
         o_last_ff <= t_last_ff;
         o_row_ff  <= t_row_ff;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.row_index = o_row_ff;
   assign rsp_ch.sum       = o_sum_ff;
   assign rsp_ch.saturated = sat_ff;
   assign rsp_ch.last      = o_last_ff;

endmodule

>>> rtl/matrix_vector_product_unit.sv
// ----------------------------------------------------------------------------
// matrix_vector_product_unit
// Dense y = A * x: vector loads fill a store, matrix elements stream row-major.
// Throughput: one request per cycle, loads and matrix elements alike, unless
// result back-pressure fills the queue. A row result passes the front stage,
// queue, multiply, accumulate, shift and saturate registers in that order.
// Reset clears counters, accumulator and configuration (64 rows, 64 columns,
// shift 15); the vector store is undefined until loaded.
// ----------------------------------------------------------------------------
module matrix_vector_product_unit #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  logic     clock,
   input  logic     reset,
   mvp_req_if.sink  req_ch,
   mvp_rsp_if.source rsp_ch,
   mvp_csr_if.sink  csr_ch
);

   mvp_pkg::cfg_type cfg_ff, cfg_in;
   mvp_pkg::job_type front_job, q_job;
   logic             front_valid, q_ready, q_valid, back_ready;
   logic             csr_wr;

   assign csr_ch.ready = 1'b1;
   assign csr_wr       = csr_ch.valid && csr_ch.ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (csr_ch.index)
            mvp_pkg::CFG_NUM_ROWS: begin
               cfg_in.num_rows = csr_ch.data;
            end
            mvp_pkg::CFG_NUM_COLS: begin
               cfg_in.num_cols = csr_ch.data;
            end
            mvp_pkg::CFG_FRAC_SHIFT: begin
               cfg_in.frac_shift = csr_ch.data[mvp_pkg::SHIFT_WIDTH-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.num_rows   <= mvp_pkg::NUM_ROWS_RESET;
         cfg_ff.num_cols   <= mvp_pkg::NUM_COLS_RESET;
         cfg_ff.frac_shift <= mvp_pkg::FRAC_SHIFT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mvp_front #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_ch    (req_ch),
      .job_valid (front_valid),
      .job_data  (front_job),
      .job_ready (q_ready)
   );

   mvp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_data  (front_job),
      .push_ready (q_ready),
      .pop_valid  (q_valid),
      .pop_data   (q_job),
      .pop_ready  (back_ready)
   );

   mvp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .frac_shift (cfg_ff.frac_shift),
      .job_valid  (q_valid),
      .job_data   (q_job),
      .job_ready  (back_ready),
      .rsp_ch     (rsp_ch)
   );

   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_ch.valid)
      else $error("response valid straight after reset");

   a_sat_clips: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.saturated |->
         (rsp_ch.sum == 32'sh7FFFFFFF) || (rsp_ch.sum == 32'sh80000000))
      else $error("saturated response not at a 32-bit limit");

   a_load_no_job: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready && (req_ch.cmd == mvp_pkg::CMD_LOAD_VEC)
         |=> !front_valid)
      else $error("vector load request produced a matrix job");

endmodule

>>> test/tb_matrix_vector_product_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_matrix_vector_product_unit
// Self-checking bench for the matrix-vector product unit. A table of directed
// requests and register writes runs first, then random phases of vector loads
// and row-major matrix streams over a spread of sizes and shifts. Every row
// sum is predicted at request acceptance and compared in order at the result
// port, with bursty requests and a result sink that stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_matrix_vector_product_unit;

   localparam int HALF_PERIOD  = 5;
   localparam int MAX_DIM      = 64;
   localparam int DRAIN_CYCLES = 8;
   localparam int RANDOM_ITEMS = 1600;
   localparam int HOLD_CYCLES  = 400;

   localparam logic [mvp_pkg::CFG_IDX_WIDTH-1:0]     CFG_UNUSED = 2'd3;
   localparam logic signed [mvp_pkg::DATA_WIDTH-1:0] DATA_MIN   = 16'sh8000;
   localparam logic signed [mvp_pkg::DATA_WIDTH-1:0] DATA_MAX   = 16'sh7FFF;
   localparam logic signed [mvp_pkg::SUM_WIDTH-1:0]  SUM_MIN    = 32'sh8000_0000;
   localparam logic signed [mvp_pkg::SUM_WIDTH-1:0]  SUM_MAX    = 32'sh7FFF_FFFF;

   typedef struct packed {
      logic [mvp_pkg::ROW_IDX_WIDTH-1:0]    row_index;
      logic signed [mvp_pkg::SUM_WIDTH-1:0] sum;
      logic                                 saturated;
      logic                                 last;
   } row_sum_type;

   typedef enum logic {STEP_CSR, STEP_REQ} step_kind_type;

   typedef struct packed {
      step_kind_type                         kind;
      logic [mvp_pkg::CFG_IDX_WIDTH-1:0]     reg_index;
      logic [mvp_pkg::CFG_DATA_WIDTH-1:0]    reg_data;
      mvp_pkg::cmd_type                      cmd;
      logic [mvp_pkg::VEC_IDX_WIDTH-1:0]     vec_index;
      logic signed [mvp_pkg::DATA_WIDTH-1:0] value;
      logic                                  typed;
      row_sum_type                           typed_sum;
   } step_type;

   logic clock = 1'b0;
   logic reset;

   mvp_req_if req_bus ();
   mvp_rsp_if rsp_bus ();
   mvp_csr_if csr_bus ();

   matrix_vector_product_unit uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   always #HALF_PERIOD clock = ~clock;

   // predicted block state
   logic signed [mvp_pkg::DATA_WIDTH-1:0] x_store [MAX_DIM];
   bit                                    x_loaded [MAX_DIM];
   logic signed [mvp_pkg::ACC_WIDTH-1:0]  acc_model;
   int                                    col_model;
   int                                    row_model;
   logic [mvp_pkg::DIM_WIDTH-1:0]         rows_reg;
   logic [mvp_pkg::DIM_WIDTH-1:0]         cols_reg;
   logic [mvp_pkg::SHIFT_WIDTH-1:0]       shift_reg;

   row_sum_type row_sums_due [$];
   step_type    directed_steps [$];
   int          mismatches;
   int          hold_cycles;
   int          burst_left;
   int          random_sent;

   function automatic int eff_dim(logic [mvp_pkg::DIM_WIDTH-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return int'(v);
   endfunction

   function automatic logic signed [mvp_pkg::DATA_WIDTH-1:0] random_value();
      case ($urandom_range(0, 11))
         0: return DATA_MIN;
         1: return DATA_MAX;
         2: return '0;
         3: return '1;
         default: return mvp_pkg::DATA_WIDTH'($urandom);
      endcase
   endfunction

   function automatic step_type csr_step(logic [mvp_pkg::CFG_IDX_WIDTH-1:0] index,
                                         logic [mvp_pkg::CFG_DATA_WIDTH-1:0] data);
      step_type s;
      s = '0;
      s.kind = STEP_CSR;
      s.reg_index = index;
      s.reg_data = data;
      return s;
   endfunction

   function automatic step_type req_step(mvp_pkg::cmd_type cmd,
                                         logic [mvp_pkg::VEC_IDX_WIDTH-1:0] index,
                                         logic signed [mvp_pkg::DATA_WIDTH-1:0] value);
      step_type s;
      s = '0;
      s.kind = STEP_REQ;
      s.cmd = cmd;
      s.vec_index = index;
      s.value = value;
      return s;
   endfunction

   // matrix element that closes a row whose sum is obvious
   function automatic step_type sum_step(logic signed [mvp_pkg::DATA_WIDTH-1:0] value,
                                         int row, int sum, bit sat, bit last);
      step_type s;
      s = req_step(mvp_pkg::CMD_MATRIX, '0, value);
      s.typed = 1'b1;
      s.typed_sum.row_index = mvp_pkg::ROW_IDX_WIDTH'(row);
      s.typed_sum.sum = sum;
      s.typed_sum.saturated = sat;
      s.typed_sum.last = last;
      return s;
   endfunction

   task automatic predict_row_sum(input mvp_pkg::cmd_type cmd,
                                  input logic [mvp_pkg::VEC_IDX_WIDTH-1:0] index,
                                  input logic signed [mvp_pkg::DATA_WIDTH-1:0] value,
                                  output bit done, output row_sum_type res);
      longint product;
      longint wide;
      longint shifted;
      done = 1'b0;
      res = '0;
      if (cmd == mvp_pkg::CMD_LOAD_VEC) begin
         x_store[index] = value;
         x_loaded[index] = 1'b1;
      end else begin
         product = longint'(value) * longint'(x_store[col_model]);
         acc_model = acc_model + product[mvp_pkg::ACC_WIDTH-1:0];
         col_model++;
         if (col_model >= eff_dim(cols_reg)) begin
            wide = longint'(acc_model);
            shifted = wide >>> shift_reg;
            res.saturated = 1'b1;
            if (shifted > longint'(SUM_MAX)) begin
               res.sum = SUM_MAX;
            end else if (shifted < longint'(SUM_MIN)) begin
               res.sum = SUM_MIN;
            end else begin
               res.sum = shifted[mvp_pkg::SUM_WIDTH-1:0];
               res.saturated = 1'b0;
            end
            res.last = (row_model + 1 >= eff_dim(rows_reg));
            res.row_index = mvp_pkg::ROW_IDX_WIDTH'(row_model);
            acc_model = '0;
            col_model = 0;
            row_model = res.last ? 0 : row_model + 1;
            done = 1'b1;
         end
      end
   endtask

   task automatic send_request(input mvp_pkg::cmd_type cmd,
                               input logic [mvp_pkg::VEC_IDX_WIDTH-1:0] index,
                               input logic signed [mvp_pkg::DATA_WIDTH-1:0] value,
                               input bit typed, input row_sum_type typed_sum);
      bit          done;
      row_sum_type res;
      req_bus.valid <= 1'b1;
      req_bus.cmd <= cmd;
      req_bus.vec_index <= index;
      req_bus.value <= value;
      do @(posedge clock); while (!req_bus.ready);
      predict_row_sum(cmd, index, value, done, res);
      if (done) row_sums_due.push_back(typed ? typed_sum : res);
      burst_left--;
      if (burst_left <= 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 40);
      end
   endtask

   // hold requests until every sum is back and the pipe has emptied
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (row_sums_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [mvp_pkg::CFG_IDX_WIDTH-1:0] index,
                            input logic [mvp_pkg::CFG_DATA_WIDTH-1:0] data);
      wait_idle();
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data <= data;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      case (index)
         mvp_pkg::CFG_NUM_ROWS:   rows_reg = data;
         mvp_pkg::CFG_NUM_COLS:   cols_reg = data;
         mvp_pkg::CFG_FRAC_SHIFT: shift_reg = data[mvp_pkg::SHIFT_WIDTH-1:0];
         default: ;
      endcase
   endtask

   initial begin : result_sink
      row_sum_type want;
      int          mode;
      int          mode_left;
      mode = 0;
      mode_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (row_sums_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t unexpected row sum: row %0d sum %0d sat %0b last %0b",
                           $realtime, rsp_bus.row_index, rsp_bus.sum, rsp_bus.saturated,
                           rsp_bus.last);
            end else begin
               want = row_sums_due.pop_front();
               if (rsp_bus.row_index !== want.row_index || rsp_bus.sum !== want.sum ||
                   rsp_bus.saturated !== want.saturated || rsp_bus.last !== want.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"%0t row sum mismatch: expected row %0d sum %0d sat %0b ",
                               "last %0b, got row %0d sum %0d sat %0b last %0b"},
                              $realtime, want.row_index, want.sum, want.saturated, want.last,
                              rsp_bus.row_index, rsp_bus.sum, rsp_bus.saturated,
                              rsp_bus.last);
               end
            end
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_bus.ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode = $urandom_range(0, 3);
               mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
               0: rsp_bus.ready <= 1'b1;
               1: rsp_bus.ready <= 1'($urandom_range(0, 1));
               2: rsp_bus.ready <= (mode_left % 3 != 0);
               default: rsp_bus.ready <= ($urandom_range(0, 4) == 0);
            endcase
         end
      end
   end

   initial begin : watchdog
      #5_000_000;
      $display("FAIL matrix_vector_product_unit");
      $finish;
   end

   initial begin : stimulus
      int                              phase;
      int                              total;
      int                              stop_at;
      logic [mvp_pkg::DIM_WIDTH-1:0]   rows;
      logic [mvp_pkg::DIM_WIDTH-1:0]   cols;
      logic [mvp_pkg::SHIFT_WIDTH-1:0] shift;

      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.cmd <= mvp_pkg::CMD_LOAD_VEC;
      req_bus.vec_index <= '0;
      req_bus.value <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= mvp_pkg::CFG_NUM_ROWS;
      csr_bus.data <= '0;

      rows_reg = mvp_pkg::NUM_ROWS_RESET;
      cols_reg = mvp_pkg::NUM_COLS_RESET;
      shift_reg = mvp_pkg::FRAC_SHIFT_RESET;
      acc_model = '0;
      col_model = 0;
      row_model = 0;
      foreach (x_loaded[i]) x_loaded[i] = 1'b0;
      mismatches = 0;
      hold_cycles = 0;
      burst_left = 1;
      random_sent = 0;

      directed_steps = {
         csr_step(mvp_pkg::CFG_NUM_ROWS, 7'd2),
         csr_step(mvp_pkg::CFG_NUM_COLS, 7'd2),
         csr_step(mvp_pkg::CFG_FRAC_SHIFT, 7'd0),
         req_step(mvp_pkg::CMD_LOAD_VEC, 6'd0, DATA_MIN),
         req_step(mvp_pkg::CMD_LOAD_VEC, 6'd1, DATA_MIN),
         req_step(mvp_pkg::CMD_MATRIX, 6'd0, DATA_MIN),
         sum_step(DATA_MIN, 0, SUM_MAX, 1'b1, 1'b0),
         req_step(mvp_pkg::CMD_MATRIX, 6'd0, DATA_MAX),
         sum_step(DATA_MAX, 1, -2147418112, 1'b0, 1'b1),
         req_step(mvp_pkg::CMD_LOAD_VEC, 6'd63, DATA_MAX),
         req_step(mvp_pkg::CMD_LOAD_VEC, 6'd1, 16'sd1),
         // shift of 31 leaves only the sign
         csr_step(mvp_pkg::CFG_FRAC_SHIFT, 7'd31),
         req_step(mvp_pkg::CMD_MATRIX, 6'd0, 16'sd1),
         sum_step(-16'sd1, 0, -1, 1'b0, 1'b0),
         req_step(mvp_pkg::CMD_MATRIX, 6'd0, DATA_MAX),
         sum_step(16'sd0, 1, -1, 1'b0, 1'b1),
         // zero sizes act as one
         csr_step(mvp_pkg::CFG_NUM_ROWS, 7'd0),
         csr_step(mvp_pkg::CFG_NUM_COLS, 7'd0),
         csr_step(mvp_pkg::CFG_FRAC_SHIFT, 7'd0),
         sum_step(16'sd5, 0, -163840, 1'b0, 1'b1),
         sum_step(DATA_MIN, 0, 1073741824, 1'b0, 1'b1),
         csr_step(mvp_pkg::CFG_NUM_COLS, 7'd3),
         req_step(mvp_pkg::CMD_LOAD_VEC, 6'd1, DATA_MIN),
         req_step(mvp_pkg::CMD_LOAD_VEC, 6'd2, DATA_MIN),
         req_step(mvp_pkg::CMD_MATRIX, 6'd0, DATA_MAX),
         req_step(mvp_pkg::CMD_MATRIX, 6'd0, DATA_MAX),
         sum_step(DATA_MAX, 0, SUM_MIN, 1'b1, 1'b1),
         // sizes shrunk under a part-done row and product
         csr_step(mvp_pkg::CFG_NUM_ROWS, 7'd3),
         req_step(mvp_pkg::CMD_MATRIX, 6'd0, 16'sd7),
         req_step(mvp_pkg::CMD_MATRIX, 6'd0, 16'sd7),
         csr_step(mvp_pkg::CFG_NUM_COLS, 7'd1),
         req_step(mvp_pkg::CMD_MATRIX, 6'd0, 16'sd7),
         req_step(mvp_pkg::CMD_MATRIX, 6'd0, 16'sd1),
         csr_step(mvp_pkg::CFG_NUM_ROWS, 7'd1),
         req_step(mvp_pkg::CMD_MATRIX, 6'd0, 16'sd1),
         csr_step(CFG_UNUSED, 7'h7F),
         csr_step(mvp_pkg::CFG_FRAC_SHIFT, 7'h7F)
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_steps[i]) begin
         if (directed_steps[i].kind == STEP_CSR)
            csr_write(directed_steps[i].reg_index, directed_steps[i].reg_data);
         else
            send_request(directed_steps[i].cmd, directed_steps[i].vec_index,
                         directed_steps[i].value, directed_steps[i].typed,
                         directed_steps[i].typed_sum);
      end

      phase = 0;
      while (random_sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 7))
            0: begin
               rows = mvp_pkg::DIM_WIDTH'($urandom_range(65, 127));
               cols = 7'd1;
            end
            1: begin
               rows = mvp_pkg::DIM_WIDTH'($urandom_range(1, 2));
               cols = mvp_pkg::DIM_WIDTH'($urandom_range(64, 127));
            end
            2: begin
               rows = 7'd0;
               cols = 7'd0;
            end
            3: begin
               rows = 7'd64;
               cols = mvp_pkg::DIM_WIDTH'($urandom_range(1, 2));
            end
            default: begin
               rows = mvp_pkg::DIM_WIDTH'($urandom_range(1, 8));
               cols = mvp_pkg::DIM_WIDTH'($urandom_range(1, 8));
            end
         endcase
         // short rows so that sums pile up behind the held sink
         if (phase % 5 == 2) begin
            rows = mvp_pkg::DIM_WIDTH'($urandom_range(4, 8));
            cols = mvp_pkg::DIM_WIDTH'($urandom_range(1, 2));
         end
         case ($urandom_range(0, 3))
            0: shift = '0;
            1: shift = '1;
            default: shift = mvp_pkg::SHIFT_WIDTH'($urandom);
         endcase
         csr_write(mvp_pkg::CFG_NUM_ROWS, rows);
         csr_write(mvp_pkg::CFG_NUM_COLS, cols);
         csr_write(mvp_pkg::CFG_FRAC_SHIFT, {2'($urandom), shift});
         if ($urandom_range(0, 9) == 0)
            csr_write(CFG_UNUSED, mvp_pkg::CFG_DATA_WIDTH'($urandom));
         if (phase % 5 == 2) hold_cycles = HOLD_CYCLES;

         repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(0, 3) != 0) begin
               for (int i = 0; i < eff_dim(cols_reg); i++) begin
                  send_request(mvp_pkg::CMD_LOAD_VEC, mvp_pkg::VEC_IDX_WIDTH'(i),
                               random_value(), 1'b0, '0);
                  random_sent++;
               end
            end
            total = eff_dim(rows_reg) * eff_dim(cols_reg);
            stop_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, total - 1) : total;
            for (int e = 0; e < stop_at; e++) begin
               if ($urandom_range(0, 19) == 0) begin
                  send_request(mvp_pkg::CMD_LOAD_VEC, mvp_pkg::VEC_IDX_WIDTH'($urandom),
                               random_value(), 1'b0, '0);
                  random_sent++;
               end
               if (!x_loaded[col_model]) begin
                  send_request(mvp_pkg::CMD_LOAD_VEC, mvp_pkg::VEC_IDX_WIDTH'(col_model),
                               random_value(), 1'b0, '0);
                  random_sent++;
               end
               send_request(mvp_pkg::CMD_MATRIX, mvp_pkg::VEC_IDX_WIDTH'($urandom),
                            random_value(), 1'b0, '0);
               random_sent++;
            end
         end
         phase++;
      end

      wait_idle();
      if (mismatches == 0)
         $display("PASS matrix_vector_product_unit");
      else
         $display("FAIL matrix_vector_product_unit");
      $finish;
   end

endmodule
